@@ src/assert_macros.svh @@
// Assertion macros shared by the minimum spanning tree RTL.
// Needs a clock named clock and a synchronous reset named reset in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// Clocked property, ignored while reset is high
`define ASSERT_CLK(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);
// Clocked property, checked during reset as well
`define ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);
`else
`define ASSERT_CLK(label, prop, msg)
`define ASSERT_ALWAYS(label, prop, msg)
`endif

`endif

@@ src/pmst_pkg.sv @@
// Shared types and constants for the minimum spanning tree block.
// Used by pmst_ctrl, pmst_dp and prim_minimum_spanning_tree_top; no dependencies.
package pmst_pkg;

   // Fixed port widths
   localparam int VERTEX_W = 6;
   localparam int WEIGHT_W = 16;
   localparam int COUNT_W  = 7;

   // Vertex count after reset
   localparam logic [COUNT_W-1:0] VCOUNT_RESET = 7'd64;

   // Item operation codes
   localparam logic OP_EDGE  = 1'b0;
   localparam logic OP_START = 1'b1;

   // Commands from controller to datapath
   typedef struct packed {
      logic clr_step;     // write "no edge" at the sweep address and advance
      logic edge_load;    // latch edge fields, read the stored weight
      logic edge_wr1;     // write the smaller weight at (src, dst)
      logic edge_wr2;     // write the smaller weight at (dst, src)
      logic run_init;     // reset keys and marks, select the root
      logic emit;         // load the result register with the selection
      logic relax_issue;  // read one neighbor's weight and key
   } pmst_cmd_type;

   // Status from datapath to controller
   typedef struct packed {
      logic clr_done;     // sweep address at the last entry
      logic edge_ok;      // both endpoints of the offered edge in range
      logic issue_last;   // relax read counter at the last vertex in use
      logic emit_last;    // current selection is the final one of the run
      logic out_free;     // result register free this cycle
   } pmst_sts_type;

endpackage

@@ src/prim_minimum_spanning_tree_top.sv @@
// Top level of the minimum spanning tree block.
// Depends on pmst_pkg, pmst_ctrl and pmst_dp.
//
// Usage: an item on the req_ channel either adds an undirected edge (op 0)
// or starts a tree run rooted at vertex 0 (op 1). A parallel edge keeps
// the smaller weight; edges stay stored across runs. csr_wr_en/csr_wr_data
// set the number of vertices in use; the user must write them only while
// the block is idle, which the block itself does not enforce. An edge item
// produces no result. A run emits one rsp_ item per vertex in use, in
// selection order, rsp_last on the final one. The first result is loaded
// into the result register after the start item is accepted; each following
// one needs a full pass over the vertices in use through the key memory.
// The result register lets the run continue while rsp_stall holds a result;
// the next selection then waits until that result is taken.
// After reset the weight matrix is cleared one entry a cycle, all
// 2**(2*ceil(log2(MAX_VERTICES))) entries (4096 by default); req_stall stays
// high through that sweep and whenever a run or edge update is in progress.

module prim_minimum_spanning_tree_top #(
   parameter int MAX_VERTICES = 64,
   parameter int WEIGHT_BITS  = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_wr_en,
   input  logic [pmst_pkg::COUNT_W-1:0]  csr_wr_data,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic                          req_op,
   input  logic [pmst_pkg::VERTEX_W-1:0] req_src_vertex,
   input  logic [pmst_pkg::VERTEX_W-1:0] req_dst_vertex,
   input  logic [pmst_pkg::WEIGHT_W-1:0] req_edge_weight,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [pmst_pkg::VERTEX_W-1:0] rsp_vertex,
   output logic [pmst_pkg::VERTEX_W-1:0] rsp_parent_vertex,
   output logic [pmst_pkg::WEIGHT_W-1:0] rsp_join_weight,
   output logic                          rsp_reached,
   output logic                          rsp_last
);
   import pmst_pkg::*;

   pmst_cmd_type cmd;
   pmst_sts_type sts;

   // Sequence edge updates, runs and the reset sweep
   pmst_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_op    (req_op),
      .cmd       (cmd),
      .sts       (sts)
   );

   // Hold the graph, keys and the result register
   pmst_dp #(
      .MAX_VERTICES (MAX_VERTICES),
      .WEIGHT_BITS  (WEIGHT_BITS)
   ) u_dp (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .sts               (sts),
      .csr_wr_en         (csr_wr_en),
      .csr_wr_data       (csr_wr_data),
      .req_src_vertex    (req_src_vertex),
      .req_dst_vertex    (req_dst_vertex),
      .req_edge_weight   (req_edge_weight),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_vertex        (rsp_vertex),
      .rsp_parent_vertex (rsp_parent_vertex),
      .rsp_join_weight   (rsp_join_weight),
      .rsp_reached       (rsp_reached),
      .rsp_last          (rsp_last)
   );

endmodule

@@ src/pmst_ctrl.sv @@
// Controller state machine for the minimum spanning tree block.
// Depends on pmst_pkg and assert_macros.svh; drives pmst_dp through command structs.
`include "assert_macros.svh"

module pmst_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic                  req_op,
   output pmst_pkg::pmst_cmd_type cmd,
   input  pmst_pkg::pmst_sts_type sts
);
   import pmst_pkg::*;

   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_EDGE_WR1,
      S_EDGE_WR2,
      S_EMIT,
      S_RELAX,
      S_DRAIN
   } state_type;

   state_type state_ff, state_in;
   logic      req_stall_ff;
   logic      accept;

   assign req_stall = req_stall_ff;
   assign accept    = req_valid && !req_stall_ff;

   // Decode next state and datapath commands
   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      case (state_ff)
         S_CLEAR: begin
            cmd.clr_step = 1'b1;
            if (sts.clr_done) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (accept) begin
               if (req_op == OP_START) begin
                  cmd.run_init = 1'b1;
                  state_in     = S_EMIT;
               end else if (sts.edge_ok) begin
                  cmd.edge_load = 1'b1;
                  state_in      = S_EDGE_WR1;
               end
            end
         end
         S_EDGE_WR1: begin
            cmd.edge_wr1 = 1'b1;
            state_in     = S_EDGE_WR2;
         end
         S_EDGE_WR2: begin
            cmd.edge_wr2 = 1'b1;
            state_in     = S_IDLE;
         end
         S_EMIT: begin
            if (sts.out_free) begin
               cmd.emit = 1'b1;
               state_in = sts.emit_last ? S_IDLE : S_RELAX;
            end
         end
         S_RELAX: begin
            cmd.relax_issue = 1'b1;
            if (sts.issue_last) begin
               state_in = S_DRAIN;
            end
         end
         S_DRAIN: begin
            state_in = S_EMIT;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Hold state; stall the input side outside idle
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         req_stall_ff <= 1'b1;
      end else begin
         state_ff     <= state_in;
         req_stall_ff <= (state_in != S_IDLE);
      end
   end

   `ASSERT_CLK(a_emit_free, cmd.emit |-> sts.out_free, "emit while result register busy")
   `ASSERT_CLK(a_edge_seq, cmd.edge_load |=> cmd.edge_wr1 ##1 cmd.edge_wr2, "edge write sequence broken")
   `ASSERT_CLK(a_relax_end, (cmd.relax_issue && sts.issue_last) |=> (state_ff == S_DRAIN) ##1 (state_ff == S_EMIT), "relax pass did not end in emit")

endmodule

@@ src/pmst_dp.sv @@
// Datapath for the minimum spanning tree block: weight matrix memory, key and
// parent memory, selection tracking and the result register. Depends on pmst_pkg.
`include "assert_macros.svh"

module pmst_dp #(
   parameter int MAX_VERTICES = 64,
   parameter int WEIGHT_BITS  = 16
) (
   input  logic                            clock,
   input  logic                            reset,
   input  pmst_pkg::pmst_cmd_type          cmd,
   output pmst_pkg::pmst_sts_type          sts,
   input  logic                            csr_wr_en,
   input  logic [pmst_pkg::COUNT_W-1:0]    csr_wr_data,
   input  logic [pmst_pkg::VERTEX_W-1:0]   req_src_vertex,
   input  logic [pmst_pkg::VERTEX_W-1:0]   req_dst_vertex,
   input  logic [pmst_pkg::WEIGHT_W-1:0]   req_edge_weight,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [pmst_pkg::VERTEX_W-1:0]   rsp_vertex,
   output logic [pmst_pkg::VERTEX_W-1:0]   rsp_parent_vertex,
   output logic [pmst_pkg::WEIGHT_W-1:0]   rsp_join_weight,
   output logic                            rsp_reached,
   output logic                            rsp_last
);
   import pmst_pkg::*;

   localparam int VW     = $clog2(MAX_VERTICES);
   localparam int VDEPTH = 1 << VW;
   localparam int AW     = 2 * VW;
   localparam int WDEPTH = 1 << AW;
   localparam int KW     = WEIGHT_BITS + 1;
   localparam logic [KW-1:0]      INF_KEY = {1'b1, {WEIGHT_BITS{1'b0}}};
   localparam logic [COUNT_W-1:0] MAXV    = COUNT_W'(MAX_VERTICES);

   // Weight matrix, row = first vertex, column = second
   logic [KW-1:0] wmem [WDEPTH];
   logic          w_we;
   logic [AW-1:0] w_waddr, w_raddr;
   logic [KW-1:0] w_wdata, w_rd_ff;

   // Key and parent per vertex, valid once written in this run
   logic [KW-1:0] kmem [VDEPTH];
   logic [VW-1:0] pmem [VDEPTH];
   logic [KW-1:0] key_rd_ff;
   logic [VW-1:0] par_rd_ff;
   logic [VDEPTH-1:0] kv_ff, sel_ff;

   logic [COUNT_W-1:0] vcount_ff, n_use, n_m1;
   logic [AW-1:0]      clr_addr_ff;
   logic [VW-1:0]      es_ff, ed_ff;
   logic [KW-1:0]      ew_ff, min_ff, edge_min;
   logic [31:0]        w_wide;

   logic [VW-1:0]      i_ff, k_ff, cur_ff, p_idx_ff;
   logic               p_vld_ff;
   logic [KW-1:0]      best_key_ff;
   logic [VW-1:0]      best_idx_ff, best_par_ff;
   logic               best_vld_ff;

   logic [KW-1:0]      key_i, nk;
   logic [VW-1:0]      par_i, np;
   logic               relax_hit, take, best_reached;

   logic               rsp_valid_ff;
   logic [VERTEX_W-1:0] rsp_vertex_ff, rsp_parent_ff;
   logic [WEIGHT_W-1:0] rsp_join_ff;
   logic               rsp_reached_ff, rsp_last_ff;

   // Clamp the vertex count to 1..MAX_VERTICES
   always_comb begin
      if (vcount_ff == '0) begin
         n_use = COUNT_W'(1);
      end else if (vcount_ff > MAXV) begin
         n_use = MAXV;
      end else begin
         n_use = vcount_ff;
      end
   end
   assign n_m1 = n_use - COUNT_W'(1);

   // Offered weight, taken in its low WEIGHT_BITS bits
   assign w_wide   = 32'(req_edge_weight);
   assign edge_min = (ew_ff < w_rd_ff) ? ew_ff : w_rd_ff;

   // Weight memory port selection
   always_comb begin
      w_we    = 1'b0;
      w_waddr = clr_addr_ff;
      w_wdata = INF_KEY;
      if (cmd.edge_wr1) begin
         w_we    = 1'b1;
         w_waddr = {es_ff, ed_ff};
         w_wdata = edge_min;
      end else if (cmd.edge_wr2) begin
         w_we    = 1'b1;
         w_waddr = {ed_ff, es_ff};
         w_wdata = min_ff;
      end else if (cmd.clr_step) begin
         w_we = 1'b1;
      end
      if (cmd.edge_load) begin
         w_raddr = {req_src_vertex[VW-1:0], req_dst_vertex[VW-1:0]};
      end else begin
         w_raddr = {cur_ff, i_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (w_we) begin
         wmem[w_waddr] <= w_wdata;
      end
      w_rd_ff <= wmem[w_raddr];
   end

   // Relax one neighbor: unwritten entries read as the run's start values
   always_comb begin
      if (kv_ff[p_idx_ff]) begin
         key_i = key_rd_ff;
         par_i = par_rd_ff;
      end else begin
         key_i = (p_idx_ff == '0) ? '0 : INF_KEY;
         par_i = '0;
      end
      relax_hit = p_vld_ff && !sel_ff[p_idx_ff] && !w_rd_ff[WEIGHT_BITS] && (w_rd_ff < key_i);
      nk        = relax_hit ? w_rd_ff : key_i;
      np        = relax_hit ? cur_ff : par_i;
      // Strict compare in index order keeps the lowest index on ties
      take      = p_vld_ff && !sel_ff[p_idx_ff] && (!best_vld_ff || (nk < best_key_ff));
   end

   always_ff @(posedge clock) begin
      if (relax_hit) begin
         kmem[p_idx_ff] <= w_rd_ff;
         pmem[p_idx_ff] <= cur_ff;
      end
      key_rd_ff <= kmem[i_ff];
      par_rd_ff <= pmem[i_ff];
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         vcount_ff    <= VCOUNT_RESET;
         clr_addr_ff  <= '0;
         kv_ff        <= '0;
         sel_ff       <= '0;
         i_ff         <= '0;
         k_ff         <= '0;
         p_vld_ff     <= 1'b0;
         best_vld_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            vcount_ff <= csr_wr_data;
         end
         if (cmd.clr_step) begin
            clr_addr_ff <= clr_addr_ff + AW'(1);
         end
         p_vld_ff <= cmd.relax_issue;
         if (cmd.relax_issue) begin
            i_ff <= i_ff + VW'(1);
         end
         if (relax_hit) begin
            kv_ff[p_idx_ff] <= 1'b1;
         end
         if (take) begin
            best_vld_ff <= 1'b1;
         end
         if (cmd.run_init) begin
            kv_ff       <= '0;
            sel_ff      <= '0;
            k_ff        <= '0;
            best_vld_ff <= 1'b1;
         end
         // Deliver the selection; drop the old result once taken
         if (cmd.emit) begin
            sel_ff[best_idx_ff] <= 1'b1;
            k_ff                <= k_ff + VW'(1);
            i_ff                <= '0;
            best_vld_ff         <= 1'b0;
            rsp_valid_ff        <= 1'b1;
         end else if (rsp_valid_ff && !rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign best_reached = !best_key_ff[WEIGHT_BITS];

   // Payload registers
   always_ff @(posedge clock) begin
      p_idx_ff <= i_ff;
      if (cmd.edge_load) begin
         es_ff <= req_src_vertex[VW-1:0];
         ed_ff <= req_dst_vertex[VW-1:0];
         ew_ff <= {1'b0, w_wide[WEIGHT_BITS-1:0]};
      end
      if (cmd.edge_wr1) begin
         min_ff <= edge_min;
      end
      if (cmd.run_init) begin
         best_idx_ff <= '0;
         best_key_ff <= '0;
         best_par_ff <= '0;
      end else if (take) begin
         best_idx_ff <= p_idx_ff;
         best_key_ff <= nk;
         best_par_ff <= np;
      end
      if (cmd.emit) begin
         cur_ff         <= best_idx_ff;
         rsp_vertex_ff  <= VERTEX_W'(best_idx_ff);
         rsp_parent_ff  <= VERTEX_W'(best_par_ff);
         rsp_join_ff    <= best_reached ? WEIGHT_W'(best_key_ff[WEIGHT_BITS-1:0]) : '0;
         rsp_reached_ff <= best_reached;
         rsp_last_ff    <= sts.emit_last;
      end
   end

   // Status to the controller
   always_comb begin
      sts            = '0;
      sts.clr_done   = &clr_addr_ff;
      sts.edge_ok    = (COUNT_W'(req_src_vertex) < MAXV) && (COUNT_W'(req_dst_vertex) < MAXV);
      sts.issue_last = (COUNT_W'(i_ff) == n_m1);
      sts.emit_last  = (COUNT_W'(k_ff) == n_m1);
      sts.out_free   = !rsp_valid_ff || !rsp_stall;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_vertex        = rsp_vertex_ff;
   assign rsp_parent_vertex = rsp_parent_ff;
   assign rsp_join_weight   = rsp_join_ff;
   assign rsp_reached       = rsp_reached_ff;
   assign rsp_last          = rsp_last_ff;

   `ASSERT_CLK(a_emit_best, cmd.emit |-> best_vld_ff, "emit without a candidate vertex")
   `ASSERT_CLK(a_emit_fresh, cmd.emit |-> !sel_ff[best_idx_ff], "vertex selected twice")
   `ASSERT_CLK(a_sel_count, cmd.emit |-> ($countones(sel_ff) == int'(k_ff)), "selection count off")

endmodule
